/* src/lsfs_pkg.sv */
// Shared types, constants and helpers of the LED strip frame serializer.
package lsfs_pkg;

    // Default size of the pixel store.
    localparam int PIXELS_MAX_DEF = 1024;

    // Frame word constants.
    localparam logic [31:0] OFF_WORD     = 32'hE000_0000;
    localparam logic [31:0] KEEP_MASK    = 32'hE0FF_FFFF;
    localparam logic [2:0]  HEADER_BITS  = 3'b111;
    localparam logic [4:0]  WORD_TOP_BIT = 5'd31;

    // Operation codes.
    localparam logic [2:0] OP_SET    = 3'd0;
    localparam logic [2:0] OP_FILL   = 3'd1;
    localparam logic [2:0] OP_BRIGHT = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_PACK   = 3'd4;
    localparam logic [2:0] OP_SHOW   = 3'd5;
    localparam logic [2:0] OP_TICK   = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PIXEL_COUNT = 2'd0;
    localparam logic [1:0] CFG_COLOR_ORDER = 2'd1;
    localparam logic [1:0] CFG_FRAME_WORD  = 2'd2;

    // Reset value of the pixel count register.
    localparam logic [10:0] PIXEL_COUNT_RST = 11'd1024;

    // One request item.
    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] index_first;
        logic [15:0] index_last;
        logic [31:0] color_word;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [4:0]  brightness;
    } t_in_req;

    // One result item.
    typedef struct packed {
        logic [31:0] read_data;
        logic        data_bit;
        logic        clock_pulse;
        logic        busy_res;
        logic        frame_done;
        logic        accepted;
    } t_out_res;

    // Build a frame word from levels and brightness; swap red and blue on request.
    function automatic logic [31:0] pack_color(input logic [7:0] red,
                                               input logic [7:0] green,
                                               input logic [7:0] blue,
                                               input logic [4:0] bright,
                                               input logic       swap_rb);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = swap_rb ? blue : red;
        lo = swap_rb ? red : blue;
        return {HEADER_BITS, bright, hi, green, lo};
    endfunction

endpackage

/* src/led_strip_frame_serializer_unit.sv */
// Results: a result is registered and comes in the cycle after its request is accepted;
// reads and pixel ticks first pass the wait state, since the store read port is registered.
// Throughput: one request per cycle while results are taken and the unit is idle; a read,
// pixel tick, fill or brightness change on pixels in use holds off requests until it is done.
// Reset is synchronous and active low; a clearing pass then writes the off word into all
// PIXELS_MAX store entries, one per cycle, before the first request is taken.
module led_strip_frame_serializer_unit #(
    parameter int PIXELS_MAX = lsfs_pkg::PIXELS_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lsfs_pkg::t_in_req  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lsfs_pkg::t_out_res o_out_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int AW = (PIXELS_MAX > 1) ? $clog2(PIXELS_MAX) : 1;
    localparam int PW = $clog2(PIXELS_MAX + 1);
    localparam int FW = $clog2(PIXELS_MAX + 2);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_FILL   = 5'b00100,
        ST_SWEEP  = 5'b01000,
        ST_RDWAIT = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [PW-1:0]      r_ptr, n_ptr;
    logic [PW-1:0]      r_limit, n_limit;
    logic [AW-1:0]      r_last, n_last;
    logic [AW-1:0]      r_wr_addr, n_wr_addr;
    logic [31:0]        r_word, n_word;
    logic [4:0]         r_bright, n_bright;
    logic               r_rd_on, n_rd_on;
    logic               r_wait_bit, n_wait_bit;
    logic [4:0]         r_sel_bit, n_sel_bit;
    logic               r_sending, n_sending;
    logic [FW-1:0]      r_fp, n_fp;
    logic [4:0]         r_bitpos, n_bitpos;
    logic               r_out_valid, n_out_valid;
    lsfs_pkg::t_out_res r_out, n_out;
    logic [10:0]        r_pixel_count;
    logic               r_color_order;
    logic [31:0]        r_frame_word;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [31:0]        mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [31:0]        mem_rdata;

    logic               in_fire;
    logic               out_take;
    logic [PW-1:0]      w_count;
    logic               first_ok;
    logic               at_end;
    lsfs_pkg::t_out_res res;
    logic               hold;

    // Pixel store.
    lsfs_ram #(
        .WIDTH(32),
        .DEPTH(PIXELS_MAX)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // Handshakes.
    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_take    = r_out_valid && i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    // Pixel count in use, limited to the store size.
    assign w_count  = (17'(r_pixel_count) < 17'(PIXELS_MAX)) ? PW'(r_pixel_count)
                                                            : PW'(PIXELS_MAX);
    assign first_ok = 17'(i_in_data.index_first) < 17'(w_count);
    assign at_end   = r_fp > FW'(w_count);

    // Sequencer and store access.
    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_limit     = r_limit;
        n_last      = r_last;
        n_wr_addr   = r_wr_addr;
        n_word      = r_word;
        n_bright    = r_bright;
        n_rd_on     = r_rd_on;
        n_wait_bit  = r_wait_bit;
        n_sel_bit   = r_sel_bit;
        n_sending   = r_sending;
        n_fp        = r_fp;
        n_bitpos    = r_bitpos;
        n_out       = r_out;
        n_out_valid = r_out_valid && !out_take;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr   = '0;
        res         = '0;
        hold        = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_ptr);
                mem_wdata = lsfs_pkg::OFF_WORD;
                if (r_ptr == PW'(PIXELS_MAX - 1)) begin
                    n_ptr   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_ptr = r_ptr + PW'(1);
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    res.busy_res = r_sending;
                    unique case (i_in_data.opcode)
                        lsfs_pkg::OP_SET: begin
                            if (first_ok) begin
                                mem_we       = 1'b1;
                                mem_waddr    = AW'(i_in_data.index_first);
                                mem_wdata    = i_in_data.color_word;
                                res.accepted = 1'b1;
                            end
                        end
                        lsfs_pkg::OP_FILL: begin
                            if ((17'(i_in_data.index_last) < 17'(w_count)) &&
                                (i_in_data.index_first <= i_in_data.index_last)) begin
                                res.accepted = 1'b1;
                                n_ptr        = PW'(i_in_data.index_first);
                                n_last       = AW'(i_in_data.index_last);
                                n_word       = i_in_data.color_word;
                                n_state      = ST_FILL;
                            end
                        end
                        lsfs_pkg::OP_BRIGHT: begin
                            res.accepted = 1'b1;
                            n_bright     = i_in_data.brightness;
                            n_limit      = w_count;
                            n_ptr        = '0;
                            n_rd_on      = 1'b0;
                            if (w_count != '0) begin
                                n_state = ST_SWEEP;
                            end
                        end
                        lsfs_pkg::OP_READ: begin
                            if (first_ok) begin
                                mem_raddr    = AW'(i_in_data.index_first);
                                res.accepted = 1'b1;
                                n_wait_bit   = 1'b0;
                                hold         = 1'b1;
                                n_state      = ST_RDWAIT;
                            end
                        end
                        lsfs_pkg::OP_PACK: begin
                            res.read_data = lsfs_pkg::pack_color(i_in_data.red,
                                                                 i_in_data.green,
                                                                 i_in_data.blue,
                                                                 i_in_data.brightness,
                                                                 r_color_order);
                            res.accepted  = 1'b1;
                        end
                        lsfs_pkg::OP_SHOW: begin
                            if (!r_sending) begin
                                n_sending    = 1'b1;
                                n_fp         = '0;
                                n_bitpos     = lsfs_pkg::WORD_TOP_BIT;
                                res.accepted = 1'b1;
                                res.busy_res = 1'b1;
                            end
                        end
                        lsfs_pkg::OP_TICK: begin
                            if (r_sending) begin
                                res.clock_pulse = 1'b1;
                                res.accepted    = 1'b1;
                                // Start and end frames come from the register, pixels
                                // from the store.
                                if ((r_fp == '0) || at_end) begin
                                    res.data_bit = r_frame_word[r_bitpos];
                                end else begin
                                    mem_raddr  = AW'(r_fp - FW'(1));
                                    n_sel_bit  = r_bitpos;
                                    n_wait_bit = 1'b1;
                                    hold       = 1'b1;
                                    n_state    = ST_RDWAIT;
                                end
                                // Advance the bit and frame position.
                                if (r_bitpos == '0) begin
                                    n_bitpos = lsfs_pkg::WORD_TOP_BIT;
                                    if (at_end) begin
                                        res.frame_done = 1'b1;
                                        n_sending      = 1'b0;
                                        n_fp           = '0;
                                    end else begin
                                        n_fp = r_fp + FW'(1);
                                    end
                                end else begin
                                    n_bitpos = r_bitpos - 5'd1;
                                end
                                res.busy_res = n_sending;
                            end
                        end
                        default: begin
                            res.accepted = 1'b0;
                        end
                    endcase
                    n_out = res;
                    if (!hold) begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            ST_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_ptr);
                mem_wdata = r_word;
                if (AW'(r_ptr) == r_last) begin
                    n_state = ST_IDLE;
                end else begin
                    n_ptr = r_ptr + PW'(1);
                end
            end
            ST_SWEEP: begin
                // Write back the entry read in the previous cycle.
                if (r_rd_on) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wr_addr;
                    mem_wdata = (mem_rdata & lsfs_pkg::KEEP_MASK) |
                                {3'b000, r_bright, 24'h00_0000};
                end
                // Read the next entry, or finish once all are issued.
                if (r_ptr < r_limit) begin
                    mem_raddr = AW'(r_ptr);
                    n_wr_addr = AW'(r_ptr);
                    n_ptr     = r_ptr + PW'(1);
                    n_rd_on   = 1'b1;
                end else begin
                    n_rd_on = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            ST_RDWAIT: begin
                if (r_wait_bit) begin
                    n_out.data_bit = mem_rdata[r_sel_bit];
                end else begin
                    n_out.read_data = mem_rdata;
                end
                n_out_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_ptr       <= '0;
            r_rd_on     <= 1'b0;
            r_sending   <= 1'b0;
            r_fp        <= '0;
            r_bitpos    <= lsfs_pkg::WORD_TOP_BIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_rd_on     <= n_rd_on;
            r_sending   <= n_sending;
            r_fp        <= n_fp;
            r_bitpos    <= n_bitpos;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_limit    <= n_limit;
        r_last     <= n_last;
        r_wr_addr  <= n_wr_addr;
        r_word     <= n_word;
        r_bright   <= n_bright;
        r_wait_bit <= n_wait_bit;
        r_sel_bit  <= n_sel_bit;
        r_out      <= n_out;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_count <= lsfs_pkg::PIXEL_COUNT_RST;
            r_color_order <= 1'b0;
            r_frame_word  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lsfs_pkg::CFG_PIXEL_COUNT: r_pixel_count <= i_cfg_data[10:0];
                lsfs_pkg::CFG_COLOR_ORDER: r_color_order <= i_cfg_data[0];
                lsfs_pkg::CFG_FRAME_WORD:  r_frame_word  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

/* src/lsfs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lsfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = lsfs_pkg::PIXELS_MAX_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/lsfs_checker.sv */
// Port-level checks of the LED strip frame serializer, bound to its top level.
module lsfs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input lsfs_pkg::t_out_res o_out_data
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // A request is only taken when the result slot is free or being emptied.
    a_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!o_out_valid || i_out_ready))
        else $error("request taken with result slot full");

    // A clock pulse only comes from a carried-out tick.
    a_pulse_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.clock_pulse |-> o_out_data.accepted)
        else $error("clock pulse on a rejected request");

    // The end of a frame carries a clock pulse and ends the transmission.
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_done |->
            o_out_data.clock_pulse && !o_out_data.busy_res)
        else $error("frame done without pulse or while still busy");

    // Reset empties the result slot.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind led_strip_frame_serializer_unit lsfs_checker u_lsfs_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);
